@@ src/bfsd_pkg.sv @@
// Package for the blocking flow shop departure block.
// Holds the fixed field widths and the stage control type; no dependencies.
package bfsd_pkg;

  // Fixed field widths of the request and result streams.
  localparam int unsigned ProcWidth   = 16;
  localparam int unsigned DepWidth    = 32;
  localparam int unsigned IdxWidth    = 5;
  localparam int unsigned SumWidth    = 32;
  localparam int unsigned CfgWidth    = 6;
  localparam int unsigned InDataWidth = 16;
  localparam int unsigned OutDataWidth = 72;

  // Reset value of the machine count register.
  localparam logic [CfgWidth-1:0] CfgReset = 6'd32;

  // Control flags that travel with a request from the memory read stage.
  typedef struct packed {
    logic first;  // previous row reads as zero
    logic last;   // last machine of the job, no blocking term
  } stage_ctrl_t;

endpackage

@@ src/blocking_flowshop_departure_top.sv @@
// Top level of the blocking flow shop departure block.
// Depends on bfsd_pkg for field widths and the stage control type.
//
// Channel   Dir  Handshake                       Payload
// s_axis    in   s_axis_tvalid_i/s_axis_tready_o  tdata: proc_time; tuser: new_sequence
// m_axis    out  m_axis_tvalid_o/m_axis_tready_i  tdata: departure_time, machine_index,
//                                                 idle_block_sum; tlast: job_done
// cfg       in   cfg_we_i                         cfg_wdata_i: machines per job
//
// One request per cycle is sustained while the result stream accepts. A request passes
// through the memory read stage (the previous-row memory has a registered read) and
// then sits in the output register, which drives the result stream.
// Reset clears the control state; the row memory holds no reset value and needs no
// clearing pass. A stalled output holds the read stage, which then stops new requests.
module blocking_flowshop_departure_top #(
  parameter int unsigned MAX_MACHINES = 32,
  parameter int unsigned TIME_WIDTH   = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write.
  input  logic                               cfg_we_i,
  input  logic [bfsd_pkg::CfgWidth-1:0]      cfg_wdata_i,   // machines per job
  // Request stream.
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [bfsd_pkg::InDataWidth-1:0]   s_axis_tdata_i, // [15:0] proc_time
  input  logic                               s_axis_tuser_i, // new_sequence
  // Result stream.
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [31:0] departure_time, [36:32] machine_index, [68:37] idle_block_sum, [71:69] zero
  output logic [bfsd_pkg::OutDataWidth-1:0]  m_axis_tdata_o,
  output logic                               m_axis_tlast_o  // job_done
);

  localparam int unsigned AW = $clog2(MAX_MACHINES);
  localparam logic [8:0]  MaxM = 9'(MAX_MACHINES);
  localparam logic [8:0]  MinM = 9'd2;

  // Configuration register.
  logic [bfsd_pkg::CfgWidth-1:0] cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= bfsd_pkg::CfgReset;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // Clamp the machine count to the supported range.
  logic [8:0] m_w;
  logic [8:0] m_last;

  always_comb begin
    m_w = 9'(cfg_q);
    if (m_w < MinM) begin
      m_w = MinM;
    end else if (m_w > MaxM) begin
      m_w = MaxM;
    end
    m_last = m_w - 9'd1;
  end

  // Handshake signals.
  logic s_acc;
  logic s1_valid_q;
  logic s1_adv;
  logic out_valid_q;

  assign s1_adv          = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || s1_adv;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  // Machine position for the incoming request.
  logic          first_job_q;
  logic [AW-1:0] count_q;
  logic          in_first;
  logic [AW-1:0] in_cnt;
  logic [AW-1:0] in_j;
  logic          in_last;
  logic [AW-1:0] in_j_next;

  always_comb begin
    in_first = s_axis_tuser_i || first_job_q;
    in_cnt   = s_axis_tuser_i ? '0 : count_q;
    if (9'(in_cnt) >= m_last) begin
      in_j = AW'(m_last);
    end else begin
      in_j = in_cnt;
    end
    in_last   = (9'(in_j) == m_last);
    in_j_next = in_j + AW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_job_q <= 1'b1;
      count_q     <= '0;
    end else if (s_acc) begin
      first_job_q <= in_last ? 1'b0 : in_first;
      count_q     <= in_last ? '0 : in_j_next;
    end
  end

  // Read stage registers.
  bfsd_pkg::stage_ctrl_t               s1_ctrl_q;
  logic [AW-1:0]                       s1_j_q;
  logic [bfsd_pkg::ProcWidth-1:0]      s1_p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_ctrl_q.first <= in_first;
      s1_ctrl_q.last  <= in_last;
      s1_j_q          <= in_j;
      s1_p_q          <= s_axis_tdata_i[bfsd_pkg::ProcWidth-1:0];
    end
  end

  // Previous-row memory: one write port, two registered read ports.
  logic [TIME_WIDTH-1:0] row_mem [MAX_MACHINES];
  logic [TIME_WIDTH-1:0] rd_here_q;
  logic [TIME_WIDTH-1:0] rd_next_q;
  logic [TIME_WIDTH-1:0] dep;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      row_mem[s1_j_q] <= dep;
    end
    if (s_acc) begin
      rd_here_q <= row_mem[in_j];
      rd_next_q <= row_mem[in_j_next];
    end
  end

  // Capture the write that lands on the same edge as the read, for forwarding.
  logic                  fwd_we_q;
  logic [AW-1:0]         fwd_addr_q;
  logic [TIME_WIDTH-1:0] fwd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_we_q <= 1'b0;
    end else if (s_acc) begin
      fwd_we_q <= s1_adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      fwd_addr_q <= s1_j_q;
      fwd_data_q <= dep;
    end
  end

  // Departure recurrence and idle-plus-blocking term.
  logic [TIME_WIDTH-1:0] left_q;
  logic [TIME_WIDTH-1:0] sigma_q;
  logic [AW-1:0]         s1_j_next;
  logic [TIME_WIDTH-1:0] prev_here;
  logic [TIME_WIDTH-1:0] prev_next;
  logic [TIME_WIDTH-1:0] p_w;
  logic [TIME_WIDTH-1:0] base;
  logic [TIME_WIDTH:0]   add_sum;
  logic [TIME_WIDTH-1:0] add_sat;
  logic [TIME_WIDTH-1:0] t1;
  logic [TIME_WIDTH-1:0] term;
  logic [TIME_WIDTH-1:0] sig_base;
  logic [TIME_WIDTH:0]   sig_sum;
  logic [TIME_WIDTH-1:0] sig_new;
  logic                  j_zero;

  always_comb begin
    s1_j_next = s1_j_q + AW'(1);
    j_zero    = (s1_j_q == '0);
    p_w       = TIME_WIDTH'(s1_p_q);

    // Forward the value written on the read edge, and zero the row for a first job.
    prev_here = (fwd_we_q && fwd_addr_q == s1_j_q) ? fwd_data_q : rd_here_q;
    prev_next = (fwd_we_q && fwd_addr_q == s1_j_next) ? fwd_data_q : rd_next_q;
    if (s1_ctrl_q.first) begin
      prev_here = '0;
      prev_next = '0;
    end

    // Saturating add of the processing time.
    base    = j_zero ? prev_here : left_q;
    add_sum = {1'b0, base} + {1'b0, p_w};
    add_sat = add_sum[TIME_WIDTH] ? '1 : add_sum[TIME_WIDTH-1:0];

    // Blocking by the previous job on the next machine.
    dep = add_sat;
    if (!s1_ctrl_q.last && prev_next > add_sat) begin
      dep = prev_next;
    end

    // Idle plus blocking, each subtraction floored at zero.
    t1   = (dep > prev_here) ? dep - prev_here : '0;
    term = (t1 > p_w) ? t1 - p_w : '0;

    sig_base = j_zero ? '0 : sigma_q;
    sig_sum  = {1'b0, sig_base} + {1'b0, term};
    sig_new  = sig_sum[TIME_WIDTH] ? '1 : sig_sum[TIME_WIDTH-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      left_q  <= dep;
      sigma_q <= sig_new;
    end
  end

  // Output register.
  logic [bfsd_pkg::DepWidth-1:0] out_dep_q;
  logic [bfsd_pkg::IdxWidth-1:0] out_idx_q;
  logic [bfsd_pkg::SumWidth-1:0] out_sum_q;
  logic                          out_last_q;
  logic [63:0]                   dep_ext;
  logic [63:0]                   sig_ext;
  logic [7:0]                    j_ext;

  assign dep_ext = 64'(dep);
  assign sig_ext = 64'(sig_new);
  assign j_ext   = 8'(s1_j_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_dep_q  <= dep_ext[bfsd_pkg::DepWidth-1:0];
      out_idx_q  <= j_ext[bfsd_pkg::IdxWidth-1:0];
      out_last_q <= s1_ctrl_q.last;
      out_sum_q  <= s1_ctrl_q.last ? sig_ext[bfsd_pkg::SumWidth-1:0] : '0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {3'b000, out_sum_q, out_idx_q, out_dep_q};

  // A read stage that cannot advance keeps its request and position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_j_q))
    else $error("read stage lost a stalled request");

  // The machine counter stays inside the row memory.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) < MAX_MACHINES)
    else $error("machine counter out of range");

  // Each memory write comes with a result loaded into the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("row written without a result");

endmodule
